// ===== rtl/prsd_pkg.sv =====
// Shared types, codes and constants of the packed relocation stream decoder.
package prsd_pkg;

   localparam int unsigned MAX_NUMBER_BYTES = 10;
   localparam int unsigned COUNT_WIDTH      = 4;

   typedef enum logic [1:0] {
      ACT_FEED    = 2'd0,
      ACT_STEP    = 2'd1,
      ACT_RESTART = 2'd2,
      ACT_INVALID = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_RECORD     = 3'd0,
      ST_FINISHED   = 3'd1,
      ST_BAD_MAGIC  = 3'd2,
      ST_BIG_GROUP  = 3'd3,
      ST_OVERLONG   = 3'd4,
      ST_UNEXPECTED = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      PH_MAGIC     = 4'd0,
      PH_COUNT     = 4'd1,
      PH_BASE      = 4'd2,
      PH_GSIZE     = 4'd3,
      PH_GFLAGS    = 4'd4,
      PH_GDELTA    = 4'd5,
      PH_GINFO     = 4'd6,
      PH_GADDEND   = 4'd7,
      PH_ROFF      = 4'd8,
      PH_RINFO     = 4'd9,
      PH_RADD      = 4'd10,
      PH_RSTEP     = 4'd11,
      PH_DONE      = 4'd12,
      PH_ERR_MAGIC = 4'd13,
      PH_ERR_GROUP = 4'd14,
      PH_ERR_LONG  = 4'd15
   } phase_type;

   // Group flag bit positions.
   localparam int unsigned FLAG_INFO       = 0;
   localparam int unsigned FLAG_OFFSET     = 1;
   localparam int unsigned FLAG_ADDEND     = 2;
   localparam int unsigned FLAG_HAS_ADDEND = 3;

   localparam logic [7:0] MAGIC_BYTES [4] = '{8'h41, 8'h50, 8'h53, 8'h32};

   typedef struct packed {
      logic [63:0]            acc_next;
      logic [COUNT_WIDTH-1:0] cnt_next;
      logic                   done;
      logic                   overlong;
      logic [63:0]            value;
   } leb_result_type;

   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [63:0] offset;
      logic [63:0] info;
      logic [63:0] addend;
      logic        last;
   } result_type;

endpackage

// ===== rtl/prsd_leb128.sv =====
// One byte step of a signed LEB128 number decoder.
module prsd_leb128 (
   input  logic [63:0]                     acc,
   input  logic [prsd_pkg::COUNT_WIDTH-1:0] cnt,
   input  logic [7:0]                      byte_in,
   output prsd_pkg::leb_result_type        res
);
   import prsd_pkg::*;

   logic [6:0]             shift;
   logic [6:0]             shift_end;
   logic [COUNT_WIDTH-1:0] cnt_inc;
   logic [63:0]            merged;

   always_comb begin
      shift     = 7'(cnt) * 7'd7;
      cnt_inc   = cnt + COUNT_WIDTH'(1);
      shift_end = 7'(cnt_inc) * 7'd7;
      // Digits beyond bit 63 simply fall off the top.
      merged    = acc | ({57'd0, byte_in[6:0]} << shift);

      res.acc_next = merged;
      res.cnt_next = cnt_inc;
      res.done     = ~byte_in[7];
      res.overlong = byte_in[7] & (32'(cnt_inc) >= MAX_NUMBER_BYTES);
      res.value    = merged;
      if (shift_end < 7'd64 && byte_in[6]) begin
         res.value = merged | ({64{1'b1}} << shift_end);
      end
   end

endmodule

// ===== rtl/prsd_engine.sv =====
// Decoder state and the next-state logic for one registered transaction.
module prsd_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic [1:0]              action,
   input  logic [7:0]              stream_byte,
   output prsd_pkg::result_type    res
);
   import prsd_pkg::*;

   phase_type              phase_ff,  phase_in;
   logic [1:0]             magic_pos_ff, magic_pos_in;
   logic [63:0]            acc_ff,    acc_in;
   logic [COUNT_WIDTH-1:0] cnt_ff,    cnt_in;
   logic [63:0]            rl_ff,     rl_in;
   logic [63:0]            gl_ff,     gl_in;
   logic [63:0]            off_ff,    off_in;
   logic [63:0]            info_ff,   info_in;
   logic [63:0]            add_ff,    add_in;
   logic [3:0]             flags_ff,  flags_in;
   logic [63:0]            step_ff,   step_in;

   leb_result_type         leb;
   logic [63:0]            off_sum;
   logic [63:0]            add_sum;
   logic [63:0]            gl_dec;
   logic                   finish;

   prsd_leb128 u_leb (
      .acc     (acc_ff),
      .cnt     (cnt_ff),
      .byte_in (stream_byte),
      .res     (leb)
   );

   function automatic phase_type reloc_phase(phase_type from, logic [3:0] f);
      phase_type p;
      p = PH_RSTEP;
      if (from <= PH_ROFF && !f[FLAG_OFFSET]) begin
         p = PH_ROFF;
      end else if (from <= PH_RINFO && !f[FLAG_INFO]) begin
         p = PH_RINFO;
      end else if (f[FLAG_HAS_ADDEND] && !f[FLAG_ADDEND]) begin
         p = PH_RADD;
      end
      return p;
   endfunction

   function automatic phase_type begin_reloc(logic [3:0] f, logic [63:0] gl,
                                             logic [63:0] rl);
      phase_type p;
      if (gl != 64'd0) begin
         p = reloc_phase(PH_ROFF, f);
      end else if (rl != 64'd0) begin
         p = PH_GSIZE;
      end else begin
         p = PH_DONE;
      end
      return p;
   endfunction

   function automatic phase_type header_phase(phase_type from, logic [3:0] f,
                                              logic [63:0] gl, logic [63:0] rl);
      phase_type p;
      if (from <= PH_GDELTA && f[FLAG_OFFSET]) begin
         p = PH_GDELTA;
      end else if (from <= PH_GINFO && f[FLAG_INFO]) begin
         p = PH_GINFO;
      end else if (f[FLAG_ADDEND] && f[FLAG_HAS_ADDEND]) begin
         p = PH_GADDEND;
      end else begin
         p = begin_reloc(f, gl, rl);
      end
      return p;
   endfunction

   function automatic logic in_header(phase_type p);
      return (p == PH_GDELTA) || (p == PH_GINFO) || (p == PH_GADDEND);
   endfunction

   assign off_sum = off_ff + ((phase_ff == PH_ROFF) ? leb.value : step_ff);
   assign add_sum = add_ff + leb.value;
   assign gl_dec  = gl_ff - 64'd1;

   always_comb begin
      phase_in     = phase_ff;
      magic_pos_in = magic_pos_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      rl_in        = rl_ff;
      gl_in        = gl_ff;
      off_in       = off_ff;
      info_in      = info_ff;
      add_in       = add_ff;
      flags_in     = flags_ff;
      step_in      = step_ff;
      finish       = 1'b0;
      res          = '0;

      if (fire) begin
         case (action_type'(action))
            ACT_RESTART: begin
               phase_in     = PH_MAGIC;
               magic_pos_in = '0;
               acc_in       = '0;
               cnt_in       = '0;
               rl_in        = '0;
               gl_in        = '0;
               off_in       = '0;
               info_in      = '0;
               add_in       = '0;
               flags_in     = '0;
               step_in      = '0;
            end
            ACT_FEED, ACT_STEP: begin
               case (phase_ff)
                  PH_ERR_MAGIC: begin
                     res.valid  = 1'b1;
                     res.status = ST_BAD_MAGIC;
                  end
                  PH_ERR_GROUP: begin
                     res.valid  = 1'b1;
                     res.status = ST_BIG_GROUP;
                  end
                  PH_ERR_LONG: begin
                     res.valid  = 1'b1;
                     res.status = ST_OVERLONG;
                  end
                  PH_DONE: begin
                     res.valid  = 1'b1;
                     res.status = ST_FINISHED;
                  end
                  PH_RSTEP: begin
                     if (action_type'(action) != ACT_STEP) begin
                        res.valid  = 1'b1;
                        res.status = ST_UNEXPECTED;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  default: begin
                     if (action_type'(action) != ACT_FEED) begin
                        res.valid  = 1'b1;
                        res.status = ST_UNEXPECTED;
                     end else if (phase_ff == PH_MAGIC) begin
                        if (stream_byte != MAGIC_BYTES[magic_pos_ff]) begin
                           phase_in   = PH_ERR_MAGIC;
                           res.valid  = 1'b1;
                           res.status = ST_BAD_MAGIC;
                        end else if (magic_pos_ff == 2'd3) begin
                           magic_pos_in = '0;
                           phase_in     = PH_COUNT;
                        end else begin
                           magic_pos_in = magic_pos_ff + 2'd1;
                        end
                     end else begin
                        acc_in = leb.acc_next;
                        cnt_in = leb.cnt_next;
                        if (leb.overlong) begin
                           phase_in   = PH_ERR_LONG;
                           res.valid  = 1'b1;
                           res.status = ST_OVERLONG;
                        end else if (leb.done) begin
                           acc_in = '0;
                           cnt_in = '0;
                           case (phase_ff)
                              PH_COUNT: begin
                                 rl_in    = leb.value;
                                 phase_in = PH_BASE;
                              end
                              PH_BASE: begin
                                 off_in = leb.value;
                                 if (rl_ff == 64'd0) begin
                                    phase_in   = PH_DONE;
                                    res.valid  = 1'b1;
                                    res.status = ST_FINISHED;
                                 end else begin
                                    phase_in = PH_GSIZE;
                                 end
                              end
                              PH_GSIZE: begin
                                 if (leb.value > rl_ff) begin
                                    phase_in   = PH_ERR_GROUP;
                                    res.valid  = 1'b1;
                                    res.status = ST_BIG_GROUP;
                                 end else begin
                                    rl_in    = rl_ff - leb.value;
                                    gl_in    = leb.value;
                                    phase_in = PH_GFLAGS;
                                 end
                              end
                              PH_GFLAGS: begin
                                 flags_in = leb.value[3:0];
                                 phase_in = header_phase(PH_GDELTA, leb.value[3:0],
                                                         gl_ff, rl_ff);
                                 if (!in_header(phase_in) &&
                                     !leb.value[FLAG_HAS_ADDEND]) begin
                                    add_in = '0;
                                 end
                              end
                              PH_GDELTA: begin
                                 step_in  = leb.value;
                                 phase_in = header_phase(PH_GINFO, flags_ff, gl_ff, rl_ff);
                                 if (!in_header(phase_in) && !flags_ff[FLAG_HAS_ADDEND]) begin
                                    add_in = '0;
                                 end
                              end
                              PH_GINFO: begin
                                 info_in  = leb.value;
                                 phase_in = header_phase(PH_GADDEND, flags_ff, gl_ff, rl_ff);
                                 if (!in_header(phase_in) && !flags_ff[FLAG_HAS_ADDEND]) begin
                                    add_in = '0;
                                 end
                              end
                              PH_GADDEND: begin
                                 add_in   = flags_ff[FLAG_HAS_ADDEND] ? add_sum : '0;
                                 phase_in = begin_reloc(flags_ff, gl_ff, rl_ff);
                              end
                              PH_ROFF: begin
                                 off_in   = off_sum;
                                 phase_in = reloc_phase(PH_RINFO, flags_ff);
                                 finish   = (phase_in == PH_RSTEP);
                              end
                              PH_RINFO: begin
                                 info_in  = leb.value;
                                 phase_in = reloc_phase(PH_RADD, flags_ff);
                                 finish   = (phase_in == PH_RSTEP);
                              end
                              PH_RADD: begin
                                 add_in = add_sum;
                                 finish = 1'b1;
                              end
                              default: begin
                              end
                           endcase
                        end
                     end
                  end
               endcase
            end
            default: begin
               res.valid  = 1'b1;
               res.status = ST_UNEXPECTED;
            end
         endcase

         // Completing a relocation: apply the shared delta and emit the record.
         if (finish) begin
            if (flags_ff[FLAG_OFFSET]) begin
               off_in = off_sum;
            end
            gl_in      = gl_dec;
            phase_in   = begin_reloc(flags_ff, gl_dec, rl_ff);
            res.valid  = 1'b1;
            res.status = ST_RECORD;
            res.offset = off_in;
            res.info   = info_in;
            res.addend = add_in;
            res.last   = (gl_dec == 64'd0) && (rl_ff == 64'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAGIC;
         magic_pos_ff <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rl_ff        <= '0;
         gl_ff        <= '0;
         off_ff       <= '0;
         info_ff      <= '0;
         add_ff       <= '0;
         flags_ff     <= '0;
         step_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         magic_pos_ff <= magic_pos_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rl_ff        <= rl_in;
         gl_ff        <= gl_in;
         off_ff       <= off_in;
         info_ff      <= info_in;
         add_ff       <= add_in;
         flags_ff     <= flags_in;
         step_ff      <= step_in;
      end
   end

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      fire && action_type'(action) == ACT_RESTART |=> phase_ff == PH_MAGIC && cnt_ff == '0)
      else $error("restart did not return the decoder to the magic check");

   // The byte count only reaches the limit in the halted over-long state.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_ERR_LONG |-> 32'(cnt_ff) < MAX_NUMBER_BYTES)
      else $error("number byte count reached the overlong limit");

   a_step_has_reloc: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_RSTEP |-> gl_ff != 64'd0)
      else $error("step pending with no relocation left in the group");

endmodule

// ===== rtl/packed_relocation_stream_decoder_unit.sv =====
// Top level of the packed relocation stream decoder: input and result registers.
//
//   Channel | Direction | Handshake             | Payload
//   req_    | in        | req_valid, req_stall  | req_action, req_stream_byte
//   rsp_    | out       | rsp_valid, rsp_stall  | rsp_status, rsp_rec_offset,
//           |           |                       | rsp_rec_info, rsp_rec_addend,
//           |           |                       | rsp_is_last
//
// One transaction per clock is accepted and decoded unless req_stall holds it; a
// result passes through the input register, one decode step and the result
// register, and is taken at an edge where rsp_stall is low.
// Reset is synchronous and active high; it returns the decoder to the magic check.
// A stalled result holds the result register; the input register then holds its
// transaction and req_stall rises only while both registers are occupied.
module packed_relocation_stream_decoder_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [7:0]         req_stream_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [63:0]        rsp_rec_offset,
   output logic [63:0]        rsp_rec_info,
   output logic signed [63:0] rsp_rec_addend,
   output logic               rsp_is_last
);
   import prsd_pkg::*;

   // Input register: holds one accepted transaction until the decoder takes it.
   logic        in_valid_ff,  in_valid_in;
   logic [1:0]  in_action_ff;
   logic [7:0]  in_byte_ff;

   // Result register.
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  out_status_ff;
   logic [63:0] out_offset_ff;
   logic [63:0] out_info_ff;
   logic [63:0] out_addend_ff;
   logic        out_last_ff;

   logic        advance;
   logic        fire;
   result_type  res;

   // The decode step may proceed whenever the result register is free or being
   // emptied in this cycle.
   assign advance   = ~out_valid_ff | ~rsp_stall;
   assign fire      = in_valid_ff & advance;
   assign req_stall = in_valid_ff & ~advance;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = advance ? (fire & res.valid) : out_valid_ff;

   prsd_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .action      (in_action_ff),
      .stream_byte (in_byte_ff),
      .res         (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load only on a completed handshake or a new result.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_stream_byte;
      end
      if (fire && res.valid) begin
         out_status_ff <= res.status;
         out_offset_ff <= res.offset;
         out_info_ff   <= res.info;
         out_addend_ff <= res.addend;
         out_last_ff   <= res.last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_rec_offset = out_offset_ff;
   assign rsp_rec_info   = out_info_ff;
   assign rsp_rec_addend = $signed(out_addend_ff);
   assign rsp_is_last    = out_last_ff;

   // Error and finish transactions carry an all-zero record.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_RECORD |->
         rsp_rec_offset == 64'd0 && rsp_rec_info == 64'd0 &&
         rsp_rec_addend == 64'sd0 && !rsp_is_last)
      else $error("non-record result carries a non-zero payload");

   a_last_is_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_last |-> rsp_status == ST_RECORD)
      else $error("last flag set on a non-record result");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> out_valid_ff && in_valid_ff)
      else $error("request stalled while a register stage was free");

endmodule

// ===== dv/relocation_record_checker.sv =====
// Checker that predicts and compares the relocation records of the decoder.
`timescale 1ns / 1ps

module relocation_record_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [7:0]         req_stream_byte,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [2:0]         rsp_status,
   input  logic [63:0]        rsp_rec_offset,
   input  logic [63:0]        rsp_rec_info,
   input  logic signed [63:0] rsp_rec_addend,
   input  logic               rsp_is_last,
   output int unsigned        mismatch_count,
   output int unsigned        pending_records
);
   import prsd_pkg::*;

   localparam logic [31:0] MAGIC_WORD = "APS2";

   typedef struct packed {
      status_type  status;
      logic [63:0] offset;
      logic [63:0] info;
      logic [63:0] addend;
      logic        last;
   } record_type;

   record_type expected_records [$];
   int unsigned failures = 0;

   // Predicted decoder state.
   phase_type   stage;
   logic [1:0]  magic_index;
   logic [63:0] number_bits;
   int unsigned number_length;
   logic [63:0] relocs_remaining;
   logic [63:0] group_remaining;
   logic [63:0] cur_offset;
   logic [63:0] cur_info;
   logic [63:0] cur_addend;
   logic [3:0]  flag_set;
   logic [63:0] offset_step;

   function automatic void clear_state();
      stage            = PH_MAGIC;
      magic_index      = '0;
      number_bits      = '0;
      number_length    = 0;
      relocs_remaining = '0;
      group_remaining  = '0;
      cur_offset       = '0;
      cur_info         = '0;
      cur_addend       = '0;
      flag_set         = '0;
      offset_step      = '0;
   endfunction

   function automatic void push_status(status_type st);
      record_type rec;
      rec = '0;
      rec.status = st;
      expected_records.push_back(rec);
   endfunction

   // Picks the first field of a relocation that still has to come from the stream.
   function automatic void enter_reloc_field(phase_type from);
      if (from <= PH_ROFF && !flag_set[FLAG_OFFSET]) begin
         stage = PH_ROFF;
      end else if (from <= PH_RINFO && !flag_set[FLAG_INFO]) begin
         stage = PH_RINFO;
      end else if (from <= PH_RADD && flag_set[FLAG_HAS_ADDEND]
                   && !flag_set[FLAG_ADDEND]) begin
         stage = PH_RADD;
      end else begin
         stage = PH_RSTEP;
      end
   endfunction

   function automatic void open_relocation();
      if (group_remaining != 0) begin
         enter_reloc_field(PH_ROFF);
      end else if (relocs_remaining != 0) begin
         stage = PH_GSIZE;
      end else begin
         stage = PH_DONE;
      end
   endfunction

   function automatic void open_body();
      if (!flag_set[FLAG_HAS_ADDEND]) begin
         cur_addend = '0;
      end
      open_relocation();
   endfunction

   function automatic void enter_header_field(phase_type from);
      if (from <= PH_GDELTA && flag_set[FLAG_OFFSET]) begin
         stage = PH_GDELTA;
      end else if (from <= PH_GINFO && flag_set[FLAG_INFO]) begin
         stage = PH_GINFO;
      end else if (from <= PH_GADDEND && flag_set[FLAG_ADDEND]
                   && flag_set[FLAG_HAS_ADDEND]) begin
         stage = PH_GADDEND;
      end else begin
         open_body();
      end
   endfunction

   function automatic void emit_record();
      record_type rec;
      if (flag_set[FLAG_OFFSET]) begin
         cur_offset = cur_offset + offset_step;
      end
      group_remaining = group_remaining - 64'd1;
      rec.status = ST_RECORD;
      rec.offset = cur_offset;
      rec.info   = cur_info;
      rec.addend = cur_addend;
      rec.last   = (group_remaining == 0) && (relocs_remaining == 0);
      expected_records.push_back(rec);
      open_relocation();
   endfunction

   function automatic void take_value(logic [63:0] value);
      logic body;
      body = 1'b0;
      case (stage)
         PH_COUNT: begin
            relocs_remaining = value;
            stage = PH_BASE;
         end
         PH_BASE: begin
            cur_offset = value;
            if (relocs_remaining == 0) begin
               stage = PH_DONE;
               push_status(ST_FINISHED);
            end else begin
               stage = PH_GSIZE;
            end
         end
         PH_GSIZE: begin
            if (value > relocs_remaining) begin
               stage = PH_ERR_GROUP;
               push_status(ST_BIG_GROUP);
            end else begin
               relocs_remaining = relocs_remaining - value;
               group_remaining  = value;
               stage = PH_GFLAGS;
            end
         end
         PH_GFLAGS: begin
            flag_set = value[3:0];
            enter_header_field(PH_GDELTA);
         end
         PH_GDELTA: begin
            offset_step = value;
            enter_header_field(PH_GINFO);
         end
         PH_GINFO: begin
            cur_info = value;
            enter_header_field(PH_GADDEND);
         end
         PH_GADDEND: begin
            cur_addend = cur_addend + value;
            open_body();
         end
         PH_ROFF: begin
            cur_offset = cur_offset + value;
            enter_reloc_field(PH_RINFO);
            body = 1'b1;
         end
         PH_RINFO: begin
            cur_info = value;
            enter_reloc_field(PH_RADD);
            body = 1'b1;
         end
         PH_RADD: begin
            cur_addend = cur_addend + value;
            stage = PH_RSTEP;
            body = 1'b1;
         end
         default: begin
         end
      endcase
      if (body && stage == PH_RSTEP) begin
         emit_record();
      end
   endfunction

   // Signed LEB128 accumulation; in a tenth byte only bit 0 survives the shift.
   function automatic void feed_number_byte(logic [7:0] data);
      int unsigned shift;
      logic [63:0] value;
      shift = 7 * number_length;
      number_bits = number_bits | (64'(data[6:0]) << shift);
      number_length++;
      if (data[7]) begin
         if (number_length >= MAX_NUMBER_BYTES) begin
            stage = PH_ERR_LONG;
            push_status(ST_OVERLONG);
         end
      end else begin
         shift = shift + 7;
         if (shift < 64 && data[6]) begin
            number_bits = number_bits | ({64{1'b1}} << shift);
         end
         value = number_bits;
         number_bits = '0;
         number_length = 0;
         take_value(value);
      end
   endfunction

   function automatic void decode_item(action_type act, logic [7:0] data);
      if (act == ACT_RESTART) begin
         clear_state();
      end else if (act == ACT_INVALID) begin
         push_status(ST_UNEXPECTED);
      end else begin
         case (stage)
            PH_ERR_MAGIC: push_status(ST_BAD_MAGIC);
            PH_ERR_GROUP: push_status(ST_BIG_GROUP);
            PH_ERR_LONG:  push_status(ST_OVERLONG);
            PH_DONE:      push_status(ST_FINISHED);
            PH_RSTEP: begin
               if (act != ACT_STEP) begin
                  push_status(ST_UNEXPECTED);
               end else begin
                  emit_record();
               end
            end
            default: begin
               if (act != ACT_FEED) begin
                  push_status(ST_UNEXPECTED);
               end else if (stage == PH_MAGIC) begin
                  if (data != MAGIC_WORD[8 * (3 - magic_index) +: 8]) begin
                     stage = PH_ERR_MAGIC;
                     push_status(ST_BAD_MAGIC);
                  end else if (magic_index == 2'd3) begin
                     magic_index = '0;
                     stage = PH_COUNT;
                  end else begin
                     magic_index = magic_index + 2'd1;
                  end
               end else begin
                  feed_number_byte(data);
               end
            end
         endcase
      end
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         failures++;
      end
   endfunction

   function automatic void check_record();
      record_type want;
      if (expected_records.size() == 0) begin
         $error("result transaction with status %0d arrived while none was expected",
                rsp_status);
         failures++;
      end else begin
         want = expected_records.pop_front();
         compare_field("status", 64'(want.status), 64'(rsp_status));
         compare_field("rec_offset", want.offset, rsp_rec_offset);
         compare_field("rec_info", want.info, rsp_rec_info);
         compare_field("rec_addend", want.addend, rsp_rec_addend);
         compare_field("is_last", 64'(want.last), 64'(rsp_is_last));
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         expected_records.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_record();
         end
         if (req_valid && !req_stall) begin
            decode_item(action_type'(req_action), req_stream_byte);
         end
      end
      mismatch_count  <= failures;
      pending_records <= expected_records.size();
   end

endmodule

// ===== dv/packed_relocation_stream_decoder_unit_test.sv =====
// Top of the decoder testbench: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps

module packed_relocation_stream_decoder_unit_test;
   import prsd_pkg::*;

   localparam logic [31:0] MAGIC_WORD     = "APS2";
   // Cycles without any accepted transaction on either channel before giving up.
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   // Extra cycles to wait once nothing is pending, to cover a stray late result.
   localparam int unsigned DRAIN_CYCLES   = 8;

   logic               clock;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic [1:0]         req_action      = ACT_FEED;
   logic [7:0]         req_stream_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic [2:0]         rsp_status;
   logic [63:0]        rsp_rec_offset;
   logic [63:0]        rsp_rec_info;
   logic signed [63:0] rsp_rec_addend;
   logic               rsp_is_last;

   int unsigned mismatch_count;
   int unsigned pending_records;

   // Percentages that shape the traffic of the current phase.
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned corrupt_pct   = 0;
   int unsigned items_sent    = 0;
   int unsigned quiet_cycles  = 0;

   packed_relocation_stream_decoder_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_rec_offset  (rsp_rec_offset),
      .rsp_rec_info    (rsp_rec_info),
      .rsp_rec_addend  (rsp_rec_addend),
      .rsp_is_last     (rsp_is_last)
   );

   relocation_record_checker record_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_rec_offset  (rsp_rec_offset),
      .rsp_rec_info    (rsp_rec_info),
      .rsp_rec_addend  (rsp_rec_addend),
      .rsp_is_last     (rsp_is_last),
      .mismatch_count  (mismatch_count),
      .pending_records (pending_records)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The receiver stalls at random, at the rate chosen for the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // The watchdog restarts whenever a transaction moves on either channel, so a
   // hung decoder or a result that never comes ends the run as a failure.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Presents one transaction and waits for the edge that accepts it. A small
   // share of transactions is replaced by noise when the phase asks for it. The
   // idle loop lowers valid only in steps where nothing raises it again.
   task automatic send_item(action_type act, logic [7:0] data);
      action_type drive_act;
      logic [7:0] drive_data;
      drive_act  = act;
      drive_data = data;
      if ($urandom_range(0, 99) < corrupt_pct) begin
         drive_act  = action_type'($urandom_range(0, 3));
         drive_data = 8'($urandom_range(0, 255));
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= drive_act;
      req_stream_byte <= drive_data;
      do @(posedge clock); while (!(req_valid && !req_stall));
      items_sent++;
   endtask

   task automatic send_magic();
      for (int i = 0; i < 4; i++) begin
         send_item(ACT_FEED, MAGIC_WORD[8 * (3 - i) +: 8]);
      end
   endtask

   // Sends a value as signed LEB128. Now and then the encoding is padded with
   // redundant sign bytes, always staying within ten bytes, and once in a while
   // a step arrives where a byte is expected.
   task automatic send_number(logic [63:0] value);
      logic [63:0] rest;
      logic [7:0]  chunk;
      logic        closing;
      int unsigned pad;
      int unsigned length;
      rest    = value;
      closing = 1'b0;
      length  = 0;
      pad     = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
      if ($urandom_range(0, 39) == 0) begin
         send_item(ACT_STEP, 8'($urandom_range(0, 255)));
      end
      while (!closing) begin
         chunk   = {1'b0, rest[6:0]};
         rest    = $signed(rest) >>> 7;
         closing = (rest == '0 && !chunk[6]) || (rest == '1 && chunk[6]);
         if (closing && pad > 0 && length < 8) begin
            closing = 1'b0;
            pad--;
         end
         chunk[7] = !closing;
         send_item(ACT_FEED, chunk);
         length++;
      end
   endtask

   // Mostly short numbers, with full-width values and the signed extremes mixed in.
   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0, 1: v = {{57{v[6]}}, v[6:0]};
         2:    v = {{50{v[13]}}, v[13:0]};
         3:    v = {{32{v[31]}}, v[31:0]};
         4:    ;
         default: begin
            case ($urandom_range(0, 3))
               0:       v = '0;
               1:       v = '1;
               2:       v = 64'h7FFF_FFFF_FFFF_FFFF;
               default: v = 64'h8000_0000_0000_0000;
            endcase
         end
      endcase
      return v;
   endfunction

   // One packed table from restart to its end, with random content. A few
   // tables are broken on purpose: a wrong magic byte, an over-long number or a
   // group larger than what is left. After such an error the table is dropped.
   task automatic send_stream();
      int unsigned remaining;
      int unsigned grp_len;
      int unsigned wrong_at;
      logic [3:0]  flags;
      logic [63:0] count_value;
      logic        any_bytes;
      send_item(ACT_RESTART, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 14) == 0) begin
         wrong_at = $urandom_range(0, 3);
         for (int i = 0; i < wrong_at; i++) begin
            send_item(ACT_FEED, MAGIC_WORD[8 * (3 - i) +: 8]);
         end
         send_item(ACT_FEED, MAGIC_WORD[8 * (3 - wrong_at) +: 8]
                   ^ (8'h01 << $urandom_range(0, 7)));
         send_item(action_type'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         return;
      end
      send_magic();
      if ($urandom_range(0, 14) == 0) begin
         for (int i = 0; i < MAX_NUMBER_BYTES; i++) begin
            send_item(ACT_FEED, 8'h80 | 8'($urandom_range(0, 127)));
         end
         send_item(action_type'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         return;
      end
      // A negative count reads as a huge unsigned total that never runs out.
      if ($urandom_range(0, 19) == 0) begin
         count_value = -64'($urandom_range(1, 3));
         remaining   = 3;
      end else begin
         remaining   = $urandom_range(0, 5);
         count_value = 64'(remaining);
      end
      send_number(count_value);
      send_number(pick_value());
      while (remaining > 0) begin
         if ($urandom_range(0, 14) == 0) begin
            send_number(64'(remaining + $urandom_range(1, 3)));
            send_item(action_type'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            return;
         end
         grp_len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, remaining);
         send_number(64'(grp_len));
         // Flag bits above the fourth are ignored by the decoder.
         flags = 4'($urandom_range(0, 15));
         send_number(64'(flags) | (64'($urandom_range(0, 3)) << 4));
         if (flags[FLAG_OFFSET]) send_number(pick_value());
         if (flags[FLAG_INFO]) send_number(pick_value());
         if (flags[FLAG_ADDEND] && flags[FLAG_HAS_ADDEND]) send_number(pick_value());
         for (int r = 0; r < grp_len; r++) begin
            any_bytes = 1'b0;
            if (!flags[FLAG_OFFSET]) begin
               send_number(pick_value());
               any_bytes = 1'b1;
            end
            if (!flags[FLAG_INFO]) begin
               send_number(pick_value());
               any_bytes = 1'b1;
            end
            if (flags[FLAG_HAS_ADDEND] && !flags[FLAG_ADDEND]) begin
               send_number(pick_value());
               any_bytes = 1'b1;
            end
            // Everything shared: the relocation is released by a step, and a
            // byte offered in its place is refused.
            if (!any_bytes) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_item(ACT_FEED, 8'($urandom_range(0, 255)));
               end
               send_item(ACT_STEP, 8'($urandom_range(0, 255)));
            end
         end
         remaining = remaining - grp_len;
      end
      if ($urandom_range(0, 2) == 0) begin
         send_item(action_type'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic run_phase(int unsigned idle_pct, int unsigned hold_pct,
                            int unsigned target);
      send_idle_pct = idle_pct;
      stall_pct     = hold_pct;
      while (items_sent < target) begin
         send_stream();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed transactions, sent back to back with no noise.
      // A wrong first magic byte halts the decoder, which then repeats the error
      // for bytes and steps; the reserved action is refused in any state.
      send_item(ACT_RESTART, 8'hFF);
      send_item(ACT_FEED, 8'hFF);
      send_item(ACT_FEED, 8'h00);
      send_item(ACT_STEP, 8'h41);
      send_item(ACT_INVALID, 8'h80);
      // An empty table finishes at the end of its base offset, here minus one.
      send_item(ACT_RESTART, 8'h00);
      send_magic();
      send_item(ACT_FEED, 8'h00);
      send_item(ACT_FEED, 8'h7F);
      send_item(ACT_STEP, 8'h00);
      // A step where the count is expected, then a group of two when one is left.
      send_item(ACT_RESTART, 8'h5A);
      send_magic();
      send_item(ACT_STEP, 8'hA5);
      send_item(ACT_FEED, 8'h01);
      send_item(ACT_FEED, 8'h00);
      send_item(ACT_FEED, 8'h02);
      send_item(ACT_STEP, 8'h00);

      // Random tables under four traffic shapes: free flowing, a sparse sender,
      // a mostly stalled receiver, and light idling on both sides.
      corrupt_pct = 2;
      run_phase(0, 0, 145);
      run_phase(86, 0, 265);
      run_phase(0, 86, 385);
      run_phase(16, 16, 505);
      req_valid <= 1'b0;

      // The pending count is registered, so it is read from the next edge after the
      // last request was taken.
      @(posedge clock);
      while (pending_records != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_records == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== packed_relocation_stream_decoder_unit.f =====
rtl/prsd_pkg.sv
rtl/prsd_leb128.sv
rtl/prsd_engine.sv
rtl/packed_relocation_stream_decoder_unit.sv
dv/relocation_record_checker.sv
dv/packed_relocation_stream_decoder_unit_test.sv
